// ===== hw/rtl/lruq_pkg.sv =====
`timescale 1ns / 1ps
package lruq_pkg;

  localparam int NUM_SETS = 16;
  localparam int NUM_WAYS = 8;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int POS_W  = $clog2(NUM_WAYS);
  localparam int CNT_W  = $clog2(NUM_WAYS + 1);
  localparam int ADDR_W = SET_W + POS_W;
  localparam int WAY_W  = 3;
  localparam int SETF_W = 4;
  localparam int CFG_W  = 4;
  localparam int OCC_W  = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(NUM_WAYS);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_TOUCH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_CHK,
    ST_APPEND,
    ST_DONE
  } lruq_state_t;

  typedef struct packed {
    logic              func;
    logic [SETF_W-1:0] set_index;
    logic [WAY_W-1:0]  way_index;
  } lruq_cmd_t;

  typedef struct packed {
    logic             evicted;
    logic [WAY_W-1:0] evicted_way;
    logic [OCC_W-1:0] occupancy;
  } lruq_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lruq_sts_t;

endpackage

// ===== hw/rtl/lruq_if.sv =====
`timescale 1ns / 1ps
interface lruq_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] set_index;
  logic [2:0] way_index;

  modport source (output valid, func, set_index, way_index, input ready);
  modport sink   (input valid, func, set_index, way_index, output ready);
endinterface

interface lruq_out_if;
  logic       valid;
  logic       ready;
  logic       evicted;
  logic [2:0] evicted_way;
  logic [3:0] occupancy;

  modport source (output valid, evicted, evicted_way, occupancy, input ready);
  modport sink   (input valid, evicted, evicted_way, occupancy, output ready);
endinterface

interface lruq_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] ways_in_use;

  modport source (output valid, ways_in_use, input ready);
  modport sink   (input valid, ways_in_use, output ready);
endinterface

// ===== hw/rtl/lruq_cnt.sv =====
`timescale 1ns / 1ps
module lruq_cnt
  import lruq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SET_W-1:0] rd_set,
  output logic [CNT_W-1:0] rd_cnt,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_set,
  input  logic [CNT_W-1:0] wr_cnt
);

  logic [CNT_W-1:0] cnt_r [NUM_SETS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        cnt_r[s] <= '0;
      end
    end else if (wr_en) begin
      cnt_r[wr_set] <= wr_cnt;
    end
  end

  assign rd_cnt = cnt_r[rd_set];

endmodule

// ===== hw/rtl/lruq_seq.sv =====
`timescale 1ns / 1ps
module lruq_seq
  import lruq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lruq_cmd_t        cmd,
  input  logic [CNT_W-1:0] cap,
  input  logic             ack,
  output lruq_sts_t        sts,
  output lruq_res_t        res,
  output logic [SET_W-1:0] cnt_set,
  input  logic [CNT_W-1:0] cnt_rd,
  output logic             cnt_we,
  output logic [CNT_W-1:0] cnt_wd
);

  lruq_state_t state_r, state_nxt;

  logic             func_r, func_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [WAY_W-1:0] way_r, way_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] app_r, app_nxt;
  logic             found_r, found_nxt;
  logic             ev_r, ev_nxt;
  logic [WAY_W-1:0] evw_r, evw_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;

  logic [WAY_W-1:0]  mem [NUM_SETS * NUM_WAYS];
  logic [WAY_W-1:0]  rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WAY_W-1:0]  wr_data;

  logic match;
  logic hit;
  logic last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    set_r   <= set_nxt;
    way_r   <= way_nxt;
    n_r     <= n_nxt;
    pos_r   <= pos_nxt;
    app_r   <= app_nxt;
    found_r <= found_nxt;
    ev_r    <= ev_nxt;
    evw_r   <= evw_nxt;
    occ_r   <= occ_nxt;
  end

  // way compare unit, used by touch
  assign match = (rdata_r == way_r);
  assign hit   = (func_r == FUNC_INSERT) ? (pos_r == '0) : match;
  assign last  = ((CNT_W'(pos_r) + CNT_W'(1)) == n_r);

  assign cnt_set = set_r;
  assign rd_addr = {set_r, pos_r};

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    set_nxt   = set_r;
    way_nxt   = way_r;
    n_nxt     = n_r;
    pos_nxt   = pos_r;
    app_nxt   = app_r;
    found_nxt = found_r;
    ev_nxt    = ev_r;
    evw_nxt   = evw_r;
    occ_nxt   = occ_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = {set_r, app_r};
    wr_data   = way_r;
    cnt_we    = 1'b0;
    cnt_wd    = cnt_rd;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt  = cmd.func;
          set_nxt   = cmd.set_index[SET_W-1:0];
          way_nxt   = cmd.way_index;
          pos_nxt   = '0;
          found_nxt = 1'b0;
          ev_nxt    = 1'b0;
          evw_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        n_nxt   = cnt_rd;
        occ_nxt = cnt_rd;
        if (func_r == FUNC_INSERT) begin
          if (cnt_rd >= cap) begin
            // full: drop the oldest, then shift the rest down
            ev_nxt    = 1'b1;
            state_nxt = ST_RD;
          end else begin
            app_nxt   = cnt_rd[POS_W-1:0];
            occ_nxt   = cnt_rd + CNT_W'(1);
            cnt_we    = 1'b1;
            cnt_wd    = cnt_rd + CNT_W'(1);
            state_nxt = ST_APPEND;
          end
        end else if (cnt_rd >= CNT_W'(2)) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = {set_r, pos_r - POS_W'(1)};
          wr_data = rdata_r;
        end else if (hit) begin
          found_nxt = 1'b1;
          if (func_r == FUNC_INSERT) begin
            evw_nxt = rdata_r;
          end
        end
        if (last) begin
          app_nxt   = pos_r;
          state_nxt = (found_r || hit) ? ST_APPEND : ST_DONE;
        end else begin
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = ST_RD;
        end
      end

      ST_APPEND: begin
        wr_en     = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);

  assign res.evicted     = ev_r;
  assign res.evicted_way = evw_r;
  assign res.occupancy   = OCC_W'(occ_r);

endmodule

// ===== hw/rtl/lru_order_queue_per_set.sv =====
`timescale 1ns / 1ps
// Each accepted word reads its set count in LOAD, walks the entries through RD and CHK when
// needed, writes in APPEND when the order changes, and waits in DONE for the output register.
// One word is in flight at a time; in_ready returns once the result moves to
// the output register, which holds the sequencer while the sink stalls.
// Reset (rst_n low, synchronous): all set counts clear, ways_in_use returns to 8, the
// output register empties; the recency memory is not cleared and needs no sweep.
module lru_order_queue_per_set
  import lruq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  lruq_in_if.sink    in_ch,
  lruq_out_if.source out_ch,
  lruq_cfg_if.sink   cfg_ch
);

  // Capacity register; written only while the block is idle.
  logic [CFG_W-1:0] ways_r;
  logic [CNT_W-1:0] cap;

  // Output register: hold a finished word until the sink takes it.
  logic      out_valid_r, out_valid_nxt;
  lruq_res_t out_res_r, out_res_nxt;

  lruq_sts_t        sts;
  lruq_res_t        res;
  lruq_cmd_t        cmd;
  logic             start;
  logic             ack;
  logic [SET_W-1:0] cnt_set;
  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wd;

  assign cfg_ch.ready = sts.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      ways_r <= cfg_ch.ways_in_use;
    end
  end

  // Clamp capacity to 1..NUM_WAYS; zero acts as one.
  always_comb begin
    if (ways_r == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(ways_r) > CNT_W'(NUM_WAYS)) begin
      cap = CNT_W'(NUM_WAYS);
    end else begin
      cap = CNT_W'(ways_r);
    end
  end

  // Take a new word only when the sequencer is idle.
  assign in_ch.ready   = sts.idle;
  assign start         = in_ch.valid & sts.idle;
  assign cmd.func      = in_ch.func;
  assign cmd.set_index = in_ch.set_index;
  assign cmd.way_index = in_ch.way_index;

  // Hand the result over once the output register is free or draining.
  assign ack = sts.done & (~out_valid_r | out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_res_nxt   = out_res_r;
    if (ack) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.evicted     = out_res_r.evicted;
  assign out_ch.evicted_way = out_res_r.evicted_way;
  assign out_ch.occupancy   = out_res_r.occupancy;

  // Per-set entry counts, cleared at reset.
  lruq_cnt u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_set (cnt_set),
    .rd_cnt (cnt_rd),
    .wr_en  (cnt_we),
    .wr_set (cnt_set),
    .wr_cnt (cnt_wd)
  );

  // Sequencer: walk the set's order one position at a time through the
  // recency memory, find the way to remove, shift the rest, append the inserted or touched way.
  lruq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (cmd),
    .cap     (cap),
    .ack     (ack),
    .sts     (sts),
    .res     (res),
    .cnt_set (cnt_set),
    .cnt_rd  (cnt_rd),
    .cnt_we  (cnt_we),
    .cnt_wd  (cnt_wd)
  );

endmodule

// ===== verif/lru_order_queue_per_set_chk.sv =====
`timescale 1ns / 1ps
module lru_order_queue_per_set_chk
  import lruq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lruq_in_if   in_w,
  lruq_out_if  out_w,
  lruq_cfg_if  cfg_w,
  output int   mismatches,
  output int   owed_count,
  output int   results_seen,
  output int   evictions
);

  logic [WAY_W-1:0] recency [NUM_SETS][NUM_WAYS];
  int               fill [NUM_SETS];
  logic [CFG_W-1:0] ways_cfg;
  lruq_res_t        owed [$];

  // Update the recency order of one set and return the word it must produce.
  function automatic lruq_res_t apply_access(input lruq_cmd_t c);
    int        s;
    int        n;
    int        cap;
    int        i;
    int        k;
    bit        moved;
    lruq_res_t r;
    s = int'(c.set_index) % NUM_SETS;
    n = fill[s];
    if (n > NUM_WAYS) n = NUM_WAYS;
    cap = int'(ways_cfg);
    if (cap < 1) cap = 1;
    if (cap > NUM_WAYS) cap = NUM_WAYS;
    r = '0;
    if (c.func == FUNC_INSERT) begin
      if (n >= cap) begin
        r.evicted     = 1'b1;
        r.evicted_way = recency[s][0];
        for (i = 1; i < n; i++) recency[s][i-1] = recency[s][i];
        n--;
      end
      recency[s][n] = c.way_index;
      n++;
    end else if (n >= 2) begin
      moved = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!moved && recency[s][i] == c.way_index) begin
          for (k = i + 1; k < n; k++) recency[s][k-1] = recency[s][k];
          recency[s][n-1] = c.way_index;
          moved = 1'b1;
        end
      end
    end
    fill[s] = n;
    r.occupancy = OCC_W'(n);
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    int        j;
    lruq_cmd_t cmd;
    lruq_res_t want;
    if (!rst_n) begin
      for (j = 0; j < NUM_SETS; j++) fill[j] = 0;
      ways_cfg = CFG_RESET;
      owed.delete();
      mismatches   = 0;
      results_seen = 0;
      evictions    = 0;
    end else begin
      // Retire the oldest expectation before queueing a new one on the same edge.
      if (out_w.valid && out_w.ready) begin
        results_seen++;
        if (out_w.evicted) evictions++;
        if (owed.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, actual evicted=%0b way=%0d occupancy=%0d",
                   $time, out_w.evicted, out_w.evicted_way, out_w.occupancy);
        end else begin
          want = owed.pop_front();
          check_field("evicted", want.evicted, out_w.evicted);
          check_field("evicted_way", want.evicted_way, out_w.evicted_way);
          check_field("occupancy", want.occupancy, out_w.occupancy);
        end
      end
      if (cfg_w.valid && cfg_w.ready) ways_cfg = cfg_w.ways_in_use;
      if (in_w.valid && in_w.ready) begin
        cmd.func      = in_w.func;
        cmd.set_index = in_w.set_index;
        cmd.way_index = in_w.way_index;
        owed.push_back(apply_access(cmd));
      end
    end
    owed_count = owed.size();
  end

endmodule

// ===== verif/lru_order_queue_per_set_tb.sv =====
`timescale 1ns / 1ps
module lru_order_queue_per_set_tb;
  import lruq_pkg::*;

  // Quiet time that settle() waits after every owed word has come back.
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 146;

  logic clk;
  logic rst_n;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   words_sent;
  int   cfg_writes;
  int   ways_plan [RAND_PHASES];
  int   mismatches;
  int   owed_count;
  int   results_seen;
  int   evictions;

  lruq_in_if  in_bus ();
  lruq_out_if out_bus ();
  lruq_cfg_if cfg_bus ();

  lru_order_queue_per_set DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  lru_order_queue_per_set_chk checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_w         (in_bus),
    .out_w        (out_bus),
    .cfg_w        (cfg_bus),
    .mismatches   (mismatches),
    .owed_count   (owed_count),
    .results_seen (results_seen),
    .evictions    (evictions)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: the slowest legal run is far below this.
  initial begin
    #(5_000_000);
    $display("lru_order_queue_per_set_tb: FAIL");
    $finish;
  end

  // Stall the result channel at random; one decision per edge.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Offer one access word, idling first at the sender's rate, and hold it until taken.
  task automatic send_word(input logic func, input int set_idx, input int way_idx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.func      <= func;
    in_bus.set_index <= SETF_W'(set_idx);
    in_bus.way_index <= WAY_W'(way_idx);
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
  endtask

  // Drop valid, let the checker log the last accepted word, wait until every owed
  // word has come back, then let the pipe go quiet.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register; only called after settle().
  task automatic write_ways(input int ways);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.ways_in_use <= CFG_W'(ways);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Pick the idle rates for a phase: receiver-heavy, sender-heavy, then none.
  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        snd_idle_pct = 38;
        rcv_idle_pct = 53;
      end
      1: begin
        snd_idle_pct = 53;
        rcv_idle_pct = 38;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    int   p;
    int   n;
    int   w;
    int   set_idx;
    logic func;

    // Drive the input and configuration channels to known values before the first edge.
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.func         = FUNC_INSERT;
    in_bus.set_index    = '0;
    in_bus.way_index    = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.ways_in_use = CFG_RESET;
    snd_idle_pct        = 0;
    rcv_idle_pct        = 0;
    words_sent          = 0;
    cfg_writes          = 0;
    ways_plan = '{1, 8, 3, 0, 5, 15, 2, 7, 4, 6, 1, 8};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, capacity at its reset value of eight.
    set_idling(0);
    send_word(FUNC_TOUCH, 0, 0);            // touch on an empty set
    send_word(FUNC_INSERT, 0, 7);
    send_word(FUNC_TOUCH, 0, 7);            // touch with a single entry does nothing
    for (w = 0; w < NUM_WAYS; w++) send_word(FUNC_INSERT, 15, w);
    send_word(FUNC_INSERT, 15, 3);          // full set: evict the oldest, way 3 now twice
    send_word(FUNC_TOUCH, 15, 3);           // only the oldest copy moves to newest
    send_word(FUNC_TOUCH, 15, 0);           // absent way: no change

    // Capacity zero behaves as one; set 15 is left holding more than that.
    settle();
    write_ways(0);
    send_word(FUNC_INSERT, 15, 5);          // evict while count stays above capacity
    send_word(FUNC_TOUCH, 15, 5);
    send_word(FUNC_INSERT, 1, 2);
    send_word(FUNC_INSERT, 1, 4);

    // Capacity above the way count clamps to eight.
    settle();
    write_ways(15);
    send_word(FUNC_INSERT, 1, 4);           // duplicate insert
    send_word(FUNC_INSERT, 1, 6);
    send_word(FUNC_TOUCH, 1, 4);
    send_word(FUNC_TOUCH, 1, 1);
    send_word(FUNC_TOUCH, 2, 0);

    // Random part: crowd a few sets so they fill, evict and reorder, with the
    // rest spread over the whole index range.
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_ways(ways_plan[p]);
      set_idling(p * 3 / RAND_PHASES);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        func    = 1'($urandom_range(0, 1));
        set_idx = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        send_word(func, set_idx, $urandom_range(0, 7));
      end
    end

    settle();
    $display("Run covered %0d access words and %0d capacity writes (clamped, reduced, raised).",
             words_sent, cfg_writes);
    $display("Result words checked: %0d, of which %0d reported an eviction.",
             results_seen, evictions);
    if (mismatches == 0 && owed_count == 0) begin
      $display("lru_order_queue_per_set_tb: PASS");
    end else begin
      $display("lru_order_queue_per_set_tb: FAIL");
    end
    $finish;
  end

endmodule
